FILE: src/bmrd_pkg.sv
// Shared types and constants for the bus monitor record decoder.
`default_nettype none
package bmrd_pkg;

  localparam logic [3:0] TYPE_ERROR   = 4'h1;
  localparam logic [3:0] TYPE_TIME_LO = 4'h2;
  localparam logic [3:0] TYPE_TIME_HI = 4'h3;
  localparam logic [3:0] TYPE_CMD_A   = 4'h8;
  localparam logic [3:0] TYPE_CMD_B   = 4'hC;

  localparam logic [1:0] KIND_CMD    = 2'd0;
  localparam logic [1:0] KIND_CMD2   = 2'd1;
  localparam logic [1:0] KIND_DATA   = 2'd2;
  localparam logic [1:0] KIND_STATUS = 2'd3;

  localparam logic [2:0] REG_FILTER_ENABLE = 3'd0;
  localparam logic [2:0] REG_FILTER_BUS    = 3'd1;
  localparam logic [2:0] REG_FILTER_RT     = 3'd2;
  localparam logic [2:0] REG_FILTER_SA     = 3'd3;
  localparam logic [2:0] REG_FILTER_MC     = 3'd4;

  localparam logic [1:0] BUS_ANY  = 2'd0;
  localparam logic [1:0] BUS_A    = 2'd1;
  localparam logic [1:0] BUS_B    = 2'd2;
  localparam logic [1:0] BUS_NONE = 2'd3;

  localparam logic [5:0] FILTER_OFF = 6'h3F;

  localparam int TIME_W = 46;

  // controller -> datapath
  typedef struct packed {
    logic absorb;      // apply the accepted word to the pending transaction
    logic clear;       // drop the pending transaction
    logic idx_reset;   // restart result index
    logic idx_step;    // advance result index
    logic load_out;    // capture a result into the output register
  } bmrd_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic closing;     // accepted word closes a non-empty transaction
    logic nonempty;    // pending transaction not empty
    logic emit_ok;     // pending transaction holds a command and passes filter
    logic last_idx;    // current index is the final result
  } bmrd_status_t;

endpackage
`default_nettype wire

FILE: src/bmrd_datapath.sv
// Datapath: transaction state, word store, filter and result forming.
`default_nettype none
module bmrd_datapath #(
  parameter int STORE_DEPTH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [5:0]         cfg_data,
  input  wire logic [31:0]        word,
  input  wire bmrd_pkg::bmrd_cmd_t cmd,
  output bmrd_pkg::bmrd_status_t  status,
  output logic [92:0]             result
);
  localparam int CW = $clog2(STORE_DEPTH + 1);
  localparam int AW = $clog2(STORE_DEPTH);

  logic       fen_r;
  logic [1:0] fbus_r;
  logic [5:0] frt_r, fsa_r, fmc_r;

  logic [15:0] cmd_word_r;
  logic        cmd_seen_r, cmd_bus_b_r, second_seen_r, status_seen_r, error_seen_r;
  logic [4:0]  second_rt_r;
  logic [25:0] tlo_r;
  logic [19:0] thi_r;
  logic [45:0] msg_time_r, latest_time_r;
  logic [CW-1:0] count_r;
  logic [15:0] store [STORE_DEPTH];
  logic [5:0]  idx_r;
  logic [15:0] rd_r;

  logic [3:0]  wtype;
  logic [15:0] bw;
  assign wtype = word[31:28];
  assign bw    = word[15:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fen_r <= 1'b0; fbus_r <= bmrd_pkg::BUS_ANY;
      frt_r <= bmrd_pkg::FILTER_OFF; fsa_r <= bmrd_pkg::FILTER_OFF;
      fmc_r <= bmrd_pkg::FILTER_OFF;
    end else if (cfg_we) begin
      case (cfg_index)
        bmrd_pkg::REG_FILTER_ENABLE: fen_r  <= cfg_data[0];
        bmrd_pkg::REG_FILTER_BUS:    fbus_r <= cfg_data[1:0];
        bmrd_pkg::REG_FILTER_RT:     frt_r  <= cfg_data;
        bmrd_pkg::REG_FILTER_SA:     fsa_r  <= cfg_data;
        bmrd_pkg::REG_FILTER_MC:     fmc_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [4:0] rt, sa, wc;
  logic       tr, mode, fpass;
  logic [5:0] shown, nres;
  assign rt = cmd_word_r[15:11];
  assign tr = cmd_word_r[10];
  assign sa = cmd_word_r[9:5];
  assign wc = cmd_word_r[4:0];
  assign mode = (sa == 5'd0) || (sa == 5'd31);

  always_comb begin
    fpass = 1'b1;
    if (fen_r) begin
      if (fbus_r == bmrd_pkg::BUS_A && cmd_bus_b_r) fpass = 1'b0;
      if (fbus_r == bmrd_pkg::BUS_B && !cmd_bus_b_r) fpass = 1'b0;
      if (fbus_r == bmrd_pkg::BUS_NONE) fpass = 1'b0;
      if (frt_r != bmrd_pkg::FILTER_OFF && frt_r != {1'b0, rt}) fpass = 1'b0;
      if (fsa_r != bmrd_pkg::FILTER_OFF) begin
        if (mode || fsa_r != {1'b0, sa}) fpass = 1'b0;
      end else if (fmc_r != bmrd_pkg::FILTER_OFF) begin
        if (!mode || fmc_r != {1'b0, wc}) fpass = 1'b0;
      end
    end
  end

  always_comb begin
    shown = 6'd0;
    if (!mode) shown = (wc == 5'd0) ? 6'd32 : {1'b0, wc};
    else if ((tr && wc == 5'd17) || (!tr && wc == 5'd16)) shown = 6'd1;
    nres = (shown == 6'd0) ? 6'd1 : shown;
  end

  logic nonempty, closes;
  assign nonempty = cmd_seen_r || error_seen_r || (msg_time_r != '0) || (count_r != '0);
  assign closes = (wtype == bmrd_pkg::TYPE_ERROR) || (wtype == bmrd_pkg::TYPE_TIME_LO) ||
                  (wtype == bmrd_pkg::TYPE_TIME_HI) || (wtype == bmrd_pkg::TYPE_CMD_A) ||
                  (wtype == bmrd_pkg::TYPE_CMD_B);
  assign status.closing  = closes && nonempty;
  assign status.nonempty = nonempty;
  assign status.emit_ok  = cmd_seen_r && fpass;
  assign status.last_idx = (idx_r + 6'd1 == nres);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_word_r <= '0; cmd_seen_r <= 1'b0; cmd_bus_b_r <= 1'b0;
      second_rt_r <= '0; second_seen_r <= 1'b0; status_seen_r <= 1'b0;
      error_seen_r <= 1'b0; tlo_r <= '0; thi_r <= '0; msg_time_r <= '0;
      latest_time_r <= '0; count_r <= '0;
    end else if (cmd.clear) begin
      cmd_word_r <= '0; cmd_seen_r <= 1'b0; cmd_bus_b_r <= 1'b0;
      second_rt_r <= '0; second_seen_r <= 1'b0; status_seen_r <= 1'b0;
      error_seen_r <= 1'b0; tlo_r <= '0; thi_r <= '0; msg_time_r <= '0;
      count_r <= '0;
    end else if (cmd.absorb) begin
      if (wtype == bmrd_pkg::TYPE_ERROR) begin
        error_seen_r <= 1'b1;
      end else if (wtype == bmrd_pkg::TYPE_TIME_LO) begin
        tlo_r <= word[25:0];
        if (thi_r != '0) begin
          msg_time_r <= {thi_r, word[25:0]};
          latest_time_r <= {thi_r, word[25:0]};
        end
      end else if (wtype == bmrd_pkg::TYPE_TIME_HI) begin
        thi_r <= word[19:0];
        if (tlo_r != '0) begin
          msg_time_r <= {word[19:0], tlo_r};
          latest_time_r <= {word[19:0], tlo_r};
        end
      end else if (wtype[3]) begin
        case (wtype[1:0])
          bmrd_pkg::KIND_CMD: begin
            cmd_word_r <= bw; cmd_bus_b_r <= wtype[2]; cmd_seen_r <= 1'b1;
          end
          bmrd_pkg::KIND_CMD2: begin
            second_rt_r <= bw[15:11]; second_seen_r <= 1'b1;
          end
          bmrd_pkg::KIND_DATA: begin
            if (count_r < CW'(STORE_DEPTH)) count_r <= count_r + CW'(1);
          end
          default: status_seen_r <= 1'b1;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.absorb && wtype[3] && wtype[1:0] == bmrd_pkg::KIND_DATA &&
        count_r < CW'(STORE_DEPTH))
      store[count_r[AW-1:0]] <= bw;
  end

  // read port: address follows the next index so data is ready with it
  logic [5:0] idx_nxt;
  always_comb begin
    idx_nxt = idx_r;
    if (cmd.idx_reset) idx_nxt = 6'd0;
    else if (cmd.idx_step) idx_nxt = idx_r + 6'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) idx_r <= '0;
    else idx_r <= idx_nxt;
    rd_r <= store[idx_nxt[AW-1:0]];
  end

  logic [15:0] dval;
  assign dval = ({1'b0, idx_r} < 7'({1'b0, shown}) && CW'(idx_r) < count_r) ? rd_r : 16'd0;

  logic [45:0] tt;
  assign tt = (msg_time_r != '0) ? msg_time_r : latest_time_r;

  always_ff @(posedge clk) begin
    if (cmd.load_out)
      result <= {status.last_idx, dval, shown, !status_seen_r, second_rt_r,
                 second_seen_r, wc, sa, tr, rt, cmd_bus_b_r, tt};
  end
endmodule
`default_nettype wire

FILE: src/bmrd_ctrl.sv
// Controller: sequences absorb, flush and result emission per accepted word.
`default_nettype none
module bmrd_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_fire,
  input  wire logic                 chunk_end,
  input  wire logic                 out_tready,
  input  wire bmrd_pkg::bmrd_status_t status,
  output bmrd_pkg::bmrd_cmd_t       cmd,
  output logic                      in_tready,
  output logic                      out_tvalid
);
  typedef enum logic [2:0] {
    S_IDLE, S_CLOSE, S_EMIT1, S_ABSORB, S_END, S_EMIT2
  } state_t;

  state_t state_r, state_nxt;
  logic   out_tvalid_r, out_tvalid_nxt, ce_r, ce_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;

  logic out_free;
  assign out_free = !out_tvalid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    ce_nxt = ce_r;
    cmd = '0;
    case (state_r)
      S_IDLE: if (in_fire) begin
        ce_nxt = chunk_end;
        state_nxt = S_CLOSE;
      end
      S_CLOSE: begin
        cmd.idx_reset = 1'b1;
        if (status.closing && status.emit_ok) state_nxt = S_EMIT1;
        else begin
          if (status.closing) cmd.clear = 1'b1;
          state_nxt = S_ABSORB;
        end
      end
      S_EMIT1, S_EMIT2: if (out_free) begin
        cmd.load_out = 1'b1;
        out_tvalid_nxt = 1'b1;
        if (status.last_idx) begin
          cmd.clear = 1'b1;
          cmd.idx_reset = 1'b1;
          state_nxt = (state_r == S_EMIT1) ? S_ABSORB : S_IDLE;
        end else cmd.idx_step = 1'b1;
      end
      S_ABSORB: begin
        cmd.absorb = 1'b1;
        state_nxt = ce_r ? S_END : S_IDLE;
      end
      S_END: begin
        cmd.idx_reset = 1'b1;
        if (status.nonempty && status.emit_ok) state_nxt = S_EMIT2;
        else begin
          cmd.clear = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; out_tvalid_r <= 1'b0; ce_r <= 1'b0;
    end else begin
      state_r <= state_nxt; out_tvalid_r <= out_tvalid_nxt; ce_r <= ce_nxt;
    end
  end
endmodule
`default_nettype wire

FILE: src/bus_monitor_record_decoder.sv
// Top level of the bus monitor record decoder.
// Decodes MIL-STD-1553 monitor records into one result per displayed data word
// of each filtered transaction, or a single result when none is displayed.
// Words are taken one at a time: the next word is not accepted until the last
// one is absorbed and its results are loaded for output. Results leave the
// controller's emission loop one per cycle while the output is taken.
`default_nettype none
module bus_monitor_record_decoder #(
  parameter int STORE_DEPTH = 32
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [5:0]   cfg_data,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [31:0]  in_tdata,   // monitor_word
  input  wire logic         in_tlast,   // chunk_end
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // timetag, bus_b, rt_address, transmit, subaddress, word_count_field,
  // rt_to_rt, second_rt, no_response, words_shown, data_word, zero pad
  output logic [95:0]       out_tdata,
  output logic              out_tlast   // last_of_run
);
  bmrd_pkg::bmrd_cmd_t    cmd;
  bmrd_pkg::bmrd_status_t status;
  logic [31:0] word_r;
  logic [92:0] result;
  logic        in_fire;

  assign in_fire = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (in_fire) word_r <= in_tdata;
  end

  bmrd_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .chunk_end(in_tlast), .out_tready,
    .status, .cmd, .in_tready, .out_tvalid
  );

  bmrd_datapath #(.STORE_DEPTH(STORE_DEPTH)) u_dp (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data, .word(word_r),
    .cmd, .status, .result
  );

  assign out_tdata = {4'd0, result[91:0]};
  assign out_tlast = result[92];
endmodule
`default_nettype wire

FILE: src/bmrd_checker.sv
// Port-level checker for the bus monitor record decoder, with its bind.
`default_nettype none
module bmrd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [95:0] out_tdata,
  input wire logic        out_tlast
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[95:92] == 4'd0) else $error("pad bits set");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready) else $error("took two words");
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[75:70] > 6'd32 |-> 1'b0) else $error("bad count");
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[75:70] == 6'd0 |-> out_tlast) else $error("single not last");
endmodule

bind bus_monitor_record_decoder bmrd_checker u_chk (
  .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready, .out_tdata, .out_tlast
);
`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for the bus monitor record decoder: stream stimulus and result checks.
`timescale 1ns / 1ps
module tb_top;

  localparam int STORE_DEPTH = 32;
  localparam int GAP_MAX = 18;
  localparam int IDLE_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 20;
  localparam int ITEM_TARGET = 480;

  localparam logic [3:0] TYPE_NONE = 4'h0;

  typedef struct packed {
    logic [15:0] data_word;
    logic [5:0]  words_shown;
    logic        no_response;
    logic [4:0]  second_rt;
    logic        rt_to_rt;
    logic [4:0]  wc;
    logic [4:0]  sa;
    logic        transmit;
    logic [4:0]  rt;
    logic        bus_b;
    logic [45:0] timetag;
  } record_t;

  typedef struct packed {
    logic    last;
    record_t rec;
  } msg_result_t;

  class record_scoreboard;
    msg_result_t expected_q[$];
    int errors;
    logic       flt_en;
    logic [1:0] flt_bus;
    logic [5:0] flt_rt, flt_sa, flt_mc;
    logic [15:0] cmd_word;
    logic cmd_seen, cmd_bus_b, cmd2_seen, stat_seen, err_seen;
    logic [4:0] cmd2_rt;
    logic [25:0] t_lo;
    logic [19:0] t_hi;
    logic [45:0] msg_time, last_time;
    logic [15:0] words[STORE_DEPTH];
    int n_words;

    function new();
      errors = 0;
      flt_en = 0;
      flt_bus = bmrd_pkg::BUS_ANY;
      flt_rt = bmrd_pkg::FILTER_OFF;
      flt_sa = bmrd_pkg::FILTER_OFF;
      flt_mc = bmrd_pkg::FILTER_OFF;
      last_time = '0;
      clear();
    endfunction

    function void set_reg(logic [2:0] idx, logic [5:0] val);
      case (idx)
        bmrd_pkg::REG_FILTER_ENABLE: flt_en = val[0];
        bmrd_pkg::REG_FILTER_BUS: flt_bus = val[1:0];
        bmrd_pkg::REG_FILTER_RT: flt_rt = val;
        bmrd_pkg::REG_FILTER_SA: flt_sa = val;
        bmrd_pkg::REG_FILTER_MC: flt_mc = val;
        default: ;
      endcase
    endfunction

    function void clear();
      cmd_word = '0;
      cmd_seen = 0;
      cmd_bus_b = 0;
      cmd2_rt = '0;
      cmd2_seen = 0;
      stat_seen = 0;
      err_seen = 0;
      t_lo = '0;
      t_hi = '0;
      msg_time = '0;
      n_words = 0;
    endfunction

    function bit is_empty();
      return !cmd_seen && !err_seen && msg_time == 0 && n_words == 0;
    endfunction

    function bit passes();
      logic [4:0] sa, wc;
      bit mode;
      sa = cmd_word[9:5];
      wc = cmd_word[4:0];
      mode = (sa == 0 || sa == 5'h1F);
      if (!flt_en) return 1;
      if (flt_bus == bmrd_pkg::BUS_A && cmd_bus_b) return 0;
      if (flt_bus == bmrd_pkg::BUS_B && !cmd_bus_b) return 0;
      if (flt_bus == bmrd_pkg::BUS_NONE) return 0;
      // any negative value other than the off code has bit 5 set and never matches
      if (flt_rt != bmrd_pkg::FILTER_OFF && flt_rt != {1'b0, cmd_word[15:11]}) return 0;
      if (flt_sa != bmrd_pkg::FILTER_OFF) begin
        if (mode || flt_sa != {1'b0, sa}) return 0;
      end else if (flt_mc != bmrd_pkg::FILTER_OFF) begin
        if (!mode || flt_mc != {1'b0, wc}) return 0;
      end
      return 1;
    endfunction

    function void flush_msg();
      msg_result_t r;
      logic [4:0] sa, wc;
      int shown, n;
      if (!cmd_seen || !passes()) return;
      sa = cmd_word[9:5];
      wc = cmd_word[4:0];
      shown = 0;
      if (!(sa == 0 || sa == 5'h1F)) shown = (wc == 0) ? 32 : wc;
      else if ((cmd_word[10] && wc == 17) || (!cmd_word[10] && wc == 16)) shown = 1;
      n = (shown != 0) ? shown : 1;
      for (int i = 0; i < n; i++) begin
        r.rec.timetag = (msg_time != 0) ? msg_time : last_time;
        r.rec.bus_b = cmd_bus_b;
        r.rec.rt = cmd_word[15:11];
        r.rec.transmit = cmd_word[10];
        r.rec.sa = sa;
        r.rec.wc = wc;
        r.rec.rt_to_rt = cmd2_seen;
        r.rec.second_rt = cmd2_rt;
        r.rec.no_response = !stat_seen;
        r.rec.words_shown = 6'(shown);
        r.rec.data_word = (i < shown && i < n_words) ? words[i] : 16'h0;
        r.last = (i == n - 1);
        expected_q = {expected_q, r};
      end
    endfunction

    function void note(logic [31:0] w, logic chunk_end);
      logic [3:0] typ;
      logic [15:0] bw;
      typ = w[31:28];
      bw = w[15:0];
      if ((typ == bmrd_pkg::TYPE_ERROR || typ == bmrd_pkg::TYPE_TIME_LO ||
           typ == bmrd_pkg::TYPE_TIME_HI ||
           (typ[3] && typ[1:0] == bmrd_pkg::KIND_CMD)) && !is_empty()) begin
        flush_msg();
        clear();
      end
      if (typ == bmrd_pkg::TYPE_ERROR) begin
        err_seen = 1;
      end else if (typ == bmrd_pkg::TYPE_TIME_LO) begin
        t_lo = w[25:0];
        if (t_hi != 0) begin
          msg_time = {t_hi, t_lo};
          last_time = msg_time;
        end
      end else if (typ == bmrd_pkg::TYPE_TIME_HI) begin
        t_hi = w[19:0];
        if (t_lo != 0) begin
          msg_time = {t_hi, t_lo};
          last_time = msg_time;
        end
      end else if (typ[3]) begin
        case (typ[1:0])
          bmrd_pkg::KIND_CMD: begin
            cmd_word = bw;
            cmd_bus_b = typ[2];
            cmd_seen = 1;
          end
          bmrd_pkg::KIND_CMD2: begin
            cmd2_rt = bw[15:11];
            cmd2_seen = 1;
          end
          bmrd_pkg::KIND_DATA: begin
            // drop words past the store depth
            if (n_words < STORE_DEPTH) begin
              words[n_words] = bw;
              n_words++;
            end
          end
          default: stat_seen = 1;
        endcase
      end
      if (chunk_end) begin
        if (!is_empty()) flush_msg();
        clear();
      end
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task cmp(string name, logic [45:0] got, logic [45:0] exp_v);
      if (got !== exp_v) report($sformatf("%s got %0h exp %0h", name, got, exp_v));
    endtask

    task check(logic [95:0] raw, logic last);
      record_t g;
      msg_result_t e;
      g = raw[91:0];
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result %0h", raw));
        return;
      end
      e = expected_q.pop_front();
      cmp("timetag", g.timetag, e.rec.timetag);
      cmp("bus_b", 46'(g.bus_b), 46'(e.rec.bus_b));
      cmp("rt_address", 46'(g.rt), 46'(e.rec.rt));
      cmp("transmit", 46'(g.transmit), 46'(e.rec.transmit));
      cmp("subaddress", 46'(g.sa), 46'(e.rec.sa));
      cmp("word_count_field", 46'(g.wc), 46'(e.rec.wc));
      cmp("rt_to_rt", 46'(g.rt_to_rt), 46'(e.rec.rt_to_rt));
      cmp("second_rt", 46'(g.second_rt), 46'(e.rec.second_rt));
      cmp("no_response", 46'(g.no_response), 46'(e.rec.no_response));
      cmp("words_shown", 46'(g.words_shown), 46'(e.rec.words_shown));
      cmp("data_word", 46'(g.data_word), 46'(e.rec.data_word));
      cmp("last_of_run", 46'(last), 46'(e.last));
    endtask
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [2:0] cfg_index = '0;
  logic [5:0] cfg_data = '0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [31:0] in_tdata = '0;
  logic in_tlast = 0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [95:0] out_tdata;
  logic out_tlast;

  record_scoreboard sb = new();
  bit no_idle = 0;
  int hold_request = 0;
  int items_sent = 0;
  int idle_count = 0;

  bus_monitor_record_decoder #(.STORE_DEPTH(STORE_DEPTH)) u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  // check results before noting a request accepted at the same edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check(out_tdata, out_tlast);
      if (in_tvalid && in_tready) sb.note(in_tdata, in_tlast);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_count <= 0;
    end else if (idle_count >= IDLE_LIMIT) begin
      $display("timeout: no progress for %0d cycles", IDLE_LIMIT);
      $display("Verification failed");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  // result side: random stalls, plus one long hold-off when requested
  initial begin
    int gap;
    @(posedge clk);
    forever begin
      if (hold_request > 0) begin
        gap = hold_request;
        hold_request = 0;
      end else begin
        gap = no_idle ? 0 : $urandom_range(0, GAP_MAX);
      end
      if (gap > 0) begin
        out_tready <= 0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  task put(logic [3:0] typ, logic [26:0] entry, logic last);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {typ, 1'($urandom), entry};
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    if (typ == bmrd_pkg::TYPE_ERROR || typ == bmrd_pkg::TYPE_TIME_LO ||
        typ == bmrd_pkg::TYPE_TIME_HI || typ[3])
      items_sent++;
  endtask

  task put_bus(logic bus_b, logic [1:0] kind, logic [15:0] bw, logic last);
    put({1'b1, bus_b, kind}, {11'($urandom), bw}, last);
  endtask

  task write_reg(logic [2:0] idx, logic [5:0] val);
    in_tvalid <= 0;
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    sb.set_reg(idx, val);
  endtask

  task drain();
    in_tvalid <= 0;
    @(posedge clk);
    wait (sb.expected_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function logic [15:0] rand_command();
    logic [4:0] rt, sa, wc;
    case ($urandom_range(0, 3))
      0: rt = 5'd5;
      1: rt = 5'h1F;
      2: rt = 5'd0;
      default: rt = 5'($urandom);
    endcase
    case ($urandom_range(0, 4))
      0: sa = 5'd0;
      1: sa = 5'h1F;
      2: sa = 5'd1;
      default: sa = 5'($urandom);
    endcase
    case ($urandom_range(0, 4))
      0: wc = 5'd16;
      1: wc = 5'd17;
      2: wc = 5'd0;
      default: wc = 5'($urandom_range(1, 6));
    endcase
    return {rt, 1'($urandom), sa, wc};
  endfunction

  // one bus transaction with random content; sometimes malformed
  task send_message();
    logic bus_b;
    logic [15:0] cmd;
    int n_data;
    bus_b = $urandom;
    cmd = rand_command();
    if ($urandom_range(0, 3) != 0) begin
      put(bmrd_pkg::TYPE_TIME_LO, 27'($urandom_range(0, 3) == 0 ? 0 : $urandom), 0);
      put(bmrd_pkg::TYPE_TIME_HI, 27'($urandom_range(0, 3) == 0 ? 0 : $urandom), 0);
    end
    if ($urandom_range(0, 9) != 0) put_bus(bus_b, bmrd_pkg::KIND_CMD, cmd, 0);
    if ($urandom_range(0, 4) == 0) put_bus($urandom, bmrd_pkg::KIND_CMD2, 16'($urandom), 0);
    if ($urandom_range(0, 19) == 0) n_data = 33;
    else if (cmd[4:0] == 0 && $urandom_range(0, 1)) n_data = $urandom_range(28, 32);
    else n_data = $urandom_range(0, 6);
    for (int i = 0; i < n_data; i++)
      put_bus(bus_b, bmrd_pkg::KIND_DATA, 16'($urandom), 0);
    if ($urandom_range(0, 3) != 0) put_bus(bus_b, bmrd_pkg::KIND_STATUS, 16'($urandom), 0);
    if ($urandom_range(0, 9) == 0) put(bmrd_pkg::TYPE_ERROR, 27'($urandom), 0);
    if ($urandom_range(0, 5) == 0) put(4'($urandom), 27'($urandom), 1'($urandom));
    if ($urandom_range(0, 7) == 0) put_bus(bus_b, bmrd_pkg::KIND_STATUS, 16'($urandom), 1);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: timetag extremes, mode codes, missing data, stray words, unused types
    put(bmrd_pkg::TYPE_TIME_HI, 27'h7FFFFFF, 0);
    put(bmrd_pkg::TYPE_TIME_LO, 27'h3FFFFFF, 0);
    put_bus(0, bmrd_pkg::KIND_CMD, {5'h1F, 1'b1, 5'd0, 5'd17}, 0);
    put_bus(0, bmrd_pkg::KIND_DATA, 16'hFFFF, 0);
    put_bus(0, bmrd_pkg::KIND_STATUS, 16'h0000, 0);
    put_bus(1, bmrd_pkg::KIND_CMD, {5'h00, 1'b0, 5'h1F, 5'd16}, 0);
    put_bus(1, bmrd_pkg::KIND_CMD2, 16'hFFFF, 0);
    put(bmrd_pkg::TYPE_ERROR, 27'h0, 0);
    put_bus(1, bmrd_pkg::KIND_CMD, {5'd3, 1'b0, 5'd2, 5'd0}, 0);
    put_bus(1, bmrd_pkg::KIND_DATA, 16'h1234, 0);
    put_bus(1, bmrd_pkg::KIND_DATA, 16'h8001, 0);
    put(TYPE_NONE, 27'h7FFFFFF, 0);
    put(4'h4, 27'h0, 0);
    put(4'h7, 27'h1, 0);
    put_bus(0, bmrd_pkg::KIND_CMD, {5'd9, 1'b1, 5'd4, 5'd1}, 1);
    put_bus(0, bmrd_pkg::KIND_STATUS, 16'h5555, 0);
    put_bus(0, bmrd_pkg::KIND_CMD2, 16'hAAAA, 0);
    put_bus(0, bmrd_pkg::KIND_CMD, {5'd1, 1'b0, 5'd0, 5'd5}, 0);
    put_bus(1, bmrd_pkg::KIND_CMD, {5'd2, 1'b1, 5'd7, 5'd2}, 1);
    put(bmrd_pkg::TYPE_TIME_LO, 27'h0000001, 1);
    drain();

    for (int phase = 0; phase < 12; phase++) begin
      case (phase)
        1: begin
          write_reg(bmrd_pkg::REG_FILTER_ENABLE, 6'd1);
          write_reg(bmrd_pkg::REG_FILTER_BUS, {4'b0, bmrd_pkg::BUS_A});
        end
        2: write_reg(bmrd_pkg::REG_FILTER_BUS, {4'b0, bmrd_pkg::BUS_B});
        3: write_reg(bmrd_pkg::REG_FILTER_BUS, {4'b0, bmrd_pkg::BUS_NONE});
        4: begin
          write_reg(bmrd_pkg::REG_FILTER_BUS, {4'b0, bmrd_pkg::BUS_ANY});
          write_reg(bmrd_pkg::REG_FILTER_RT, 6'd5);
        end
        5: write_reg(bmrd_pkg::REG_FILTER_RT, 6'h20);
        6: begin
          write_reg(bmrd_pkg::REG_FILTER_RT, 6'd31);
          write_reg(bmrd_pkg::REG_FILTER_SA, 6'd1);
        end
        7: begin
          write_reg(bmrd_pkg::REG_FILTER_RT, bmrd_pkg::FILTER_OFF);
          write_reg(bmrd_pkg::REG_FILTER_SA, 6'd31);
        end
        8: begin
          write_reg(bmrd_pkg::REG_FILTER_SA, bmrd_pkg::FILTER_OFF);
          write_reg(bmrd_pkg::REG_FILTER_MC, 6'd17);
        end
        9: begin
          write_reg(bmrd_pkg::REG_FILTER_MC, 6'd0);
          write_reg(bmrd_pkg::REG_FILTER_SA, 6'h30);
        end
        10: begin
          write_reg(bmrd_pkg::REG_FILTER_SA, bmrd_pkg::FILTER_OFF);
          write_reg(bmrd_pkg::REG_FILTER_MC, 6'h21);
        end
        11: write_reg(bmrd_pkg::REG_FILTER_ENABLE, 6'd0);
        default: ;
      endcase
      no_idle = (phase % 4 == 2);
      if (phase == 3 || phase == 11) hold_request = HOLD_CYCLES;
      while (items_sent < (phase + 1) * ITEM_TARGET / 12 + 20) send_message();
      drain();
    end

    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
